### hw/rtl/tkwa_pkg.sv
package tkwa_pkg;

  // Fixed widths of the stream fields.
  localparam int CHAN_W    = 4;
  localparam int FIELD_W   = 16;
  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 72;

  // Digital button mask register.
  localparam int              MASK_W     = 9;
  localparam logic [MASK_W-1:0] MASK_RESET = 9'd384;

  // Small constants; all of them fit in the narrowest legal sample width.
  localparam logic [7:0] THRESH_RESET = 8'd70;
  localparam logic [7:0] DIGITAL_HELD = 8'd10;
  localparam logic [7:0] DIGITAL_IDLE = 8'd80;
  localparam logic [7:0] LOW_RESET    = 8'd38;

  // Configuration port.
  localparam int                    APB_ADDR_W        = 3;
  localparam int                    APB_DATA_W        = 32;
  localparam logic [APB_ADDR_W-1:0] ADDR_DIGITAL_MASK = 3'd0;

  typedef enum logic {
    OP_SAMPLE    = 1'b0,
    OP_CALIBRATE = 1'b1
  } op_t;

endpackage

### hw/rtl/tkwa_win_div.sv
// Divides a window sum by the window length with a reciprocal multiply.
// The shift is chosen so that the quotient is exact over the whole sum range.
module tkwa_win_div #(
  parameter int WINDOW = 24,
  parameter int VAL_W  = 16,
  localparam int SUM_W = VAL_W + $clog2(WINDOW)
) (
  input  logic [SUM_W-1:0] sum,
  output logic [VAL_W-1:0] quot
);

  localparam int          SH      = SUM_W + $clog2(WINDOW);
  localparam int          M_W     = SUM_W + 1;
  localparam int          PROD_W  = SUM_W + M_W;
  localparam logic [63:0] RECIP64 = ((64'd1 << SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [M_W-1:0] RECIP = RECIP64[M_W-1:0];

  logic [PROD_W-1:0] prod;

  assign prod = {{M_W{1'b0}}, sum} * {{SUM_W{1'b0}}, RECIP};
  assign quot = prod[SH +: VAL_W];

endmodule

### hw/rtl/touch_key_window_average_core.sv
// Touch key window-average qualifier. Each input word names a sensor channel
// and carries either a raw sample (tuser low) or a calibrate request (tuser
// high). Channels marked in the digital_mask register are buttons: bit 0 of
// the sample set maps to 10, clear maps to 80. Every channel keeps a ring of
// its last WINDOW values and a running sum; each item returns one result word
// with the truncated window average, a pressed flag (value below the channel
// threshold), the global low and high marks with change flags, and the
// channel threshold after the item. Calibrate sets the threshold to three
// quarters of the current average. Channels at or above CHANNELS are echoed
// with zeroed average, flags and threshold and change nothing. Throughput is
// one word per clock unless the result stream stalls; a result passes
// stage 1, stage 2 and the result register. The rate is set by the history
// memory, which is read once at acceptance and written once from stage 1, so
// neighboring items never collide on it. The memory needs no clearing pass
// after reset: a per-channel wrap flag makes unwritten entries count as zero.
module touch_key_window_average_core #(
  parameter int WINDOW      = 24,
  parameter int CHANNELS    = 9,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,

  // Input stream.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [3:0] channel, [19:4] sample, [23:20] zero.
  input  logic [tkwa_pkg::S_TDATA_W-1:0]      s_axis_tdata,
  // [0] op.
  input  logic                                s_axis_tuser,

  // Result stream.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [3:0] channel_out, [4] pressed, [20:5] window_average, [36:21] low_mark,
  // [52:37] high_mark, [53] low_changed, [54] high_changed,
  // [70:55] threshold_now, [71] zero.
  output logic [tkwa_pkg::M_TDATA_W-1:0]      m_axis_tdata,

  // Configuration port.
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tkwa_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [tkwa_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [tkwa_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  import tkwa_pkg::*;

  localparam int VAL_W  = (SAMPLE_BITS < FIELD_W) ? SAMPLE_BITS : FIELD_W;
  localparam int SLOT_W = $clog2(WINDOW);
  localparam int SUM_W  = VAL_W + SLOT_W;
  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DEPTH  = CHANNELS * WINDOW;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

  // ---------------------------------------------------------------------------
  // Configuration register.
  // ---------------------------------------------------------------------------
  logic [MASK_W-1:0] digital_mask;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_DIGITAL_MASK);

  always_ff @(posedge clk) begin
    if (rst) begin
      digital_mask <= MASK_RESET;
    end else if (cfg_wr) begin
      digital_mask <= pwdata[MASK_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_DIGITAL_MASK) begin
      prdata = APB_DATA_W'(digital_mask);
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control. All three stages move together whenever the result
  // register is empty or being drained.
  // ---------------------------------------------------------------------------
  logic en;
  logic accept;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------------------
  // Input decode, ring slot allocation and history read (acceptance edge).
  // ---------------------------------------------------------------------------
  op_t                    in_op;
  logic [CHAN_W-1:0]      in_ch;
  logic [FIELD_W-1:0]     in_sample;
  logic                   in_ok;
  logic [CH_W-1:0]        in_idx;
  logic [2**CHAN_W-1:0]   mask_ext;
  logic                   in_dig;
  logic [VAL_W-1:0]       in_val;
  logic [SLOT_W-1:0]      cur_slot;
  logic [SLOT_W-1:0]      slot_next;
  logic [ADDR_W-1:0]      rd_addr;
  logic                   in_is_sample;

  logic [SLOT_W-1:0]      write_slot [CHANNELS];
  logic [CHANNELS-1:0]    filled;

  assign in_op        = op_t'(s_axis_tuser);
  assign in_ch        = s_axis_tdata[CHAN_W-1:0];
  assign in_sample    = s_axis_tdata[CHAN_W +: FIELD_W];
  assign in_ok        = int'(in_ch) < CHANNELS;
  assign in_idx       = CH_W'(in_ch);
  assign mask_ext     = (2**CHAN_W)'(digital_mask);
  assign in_dig       = mask_ext[in_ch];
  assign in_is_sample = in_ok && (in_op == OP_SAMPLE);

  always_comb begin
    if (in_dig) begin
      in_val = in_sample[0] ? VAL_W'(DIGITAL_HELD) : VAL_W'(DIGITAL_IDLE);
    end else begin
      in_val = in_sample[VAL_W-1:0];
    end
  end

  assign cur_slot  = write_slot[in_idx];
  assign slot_next = (cur_slot == LAST_SLOT) ? '0 : cur_slot + 1'b1;
  assign rd_addr   = ADDR_W'(int'(in_idx) * WINDOW + int'(cur_slot));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        write_slot[c] <= '0;
      end
      filled <= '0;
    end else if (accept && in_is_sample) begin
      write_slot[in_idx] <= slot_next;
      if (cur_slot == LAST_SLOT) begin
        filled[in_idx] <= 1'b1;
      end
    end
  end

  // Stage 1 registers.
  logic               v1;
  op_t                s1_op;
  logic [CHAN_W-1:0]  s1_ch;
  logic               s1_ok;
  logic [VAL_W-1:0]   s1_val;
  logic [ADDR_W-1:0]  s1_addr;
  logic               s1_filled;
  logic [VAL_W-1:0]   rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op     <= in_op;
      s1_ch     <= in_ch;
      s1_ok     <= in_ok;
      s1_val    <= in_val;
      s1_addr   <= rd_addr;
      s1_filled <= in_ok && filled[in_idx];
    end
  end

  // ---------------------------------------------------------------------------
  // History memory. The entry written in a cycle is never the one read in
  // that cycle: consecutive samples of one channel use consecutive slots.
  // ---------------------------------------------------------------------------
  logic [VAL_W-1:0] hist_mem [DEPTH];
  logic             mem_we;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist_mem[s1_addr] <= s1_val;
    end
    if (accept && in_ok) begin
      rd_data <= hist_mem[rd_addr];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: running sum and global marks.
  // ---------------------------------------------------------------------------
  logic [CH_W-1:0]   s1_idx;
  logic              s1_is_sample;
  logic [VAL_W-1:0]  old_val;
  logic [SUM_W-1:0]  cur_sum;
  logic [SUM_W-1:0]  new_sum;
  logic              hi_up;
  logic              lo_dn;

  logic [SUM_W-1:0]  window_sum [CHANNELS];
  logic [VAL_W-1:0]  low_seen;
  logic [VAL_W-1:0]  high_seen;

  assign s1_idx       = CH_W'(s1_ch);
  assign s1_is_sample = s1_ok && (s1_op == OP_SAMPLE);
  assign old_val      = s1_filled ? rd_data : '0;
  assign cur_sum      = window_sum[s1_idx];
  assign new_sum      = cur_sum - SUM_W'(old_val) + SUM_W'(s1_val);
  assign hi_up        = s1_is_sample && (s1_val > high_seen);
  assign lo_dn        = s1_is_sample && (s1_val < low_seen);
  assign mem_we       = en && v1 && s1_is_sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        window_sum[c] <= '0;
      end
      low_seen  <= VAL_W'(LOW_RESET);
      high_seen <= '0;
    end else if (mem_we) begin
      window_sum[s1_idx] <= new_sum;
      if (hi_up) begin
        high_seen <= s1_val;
      end
      if (lo_dn) begin
        low_seen <= s1_val;
      end
    end
  end

  // Stage 2 registers.
  logic               v2;
  op_t                s2_op;
  logic [CHAN_W-1:0]  s2_ch;
  logic               s2_ok;
  logic [VAL_W-1:0]   s2_val;
  logic [SUM_W-1:0]   s2_sum;
  logic [VAL_W-1:0]   s2_low;
  logic [VAL_W-1:0]   s2_high;
  logic               s2_lowc;
  logic               s2_highc;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en && v1) begin
      s2_op    <= s1_op;
      s2_ch    <= s1_ch;
      s2_ok    <= s1_ok;
      s2_val   <= s1_val;
      s2_sum   <= s1_is_sample ? new_sum : (s1_ok ? cur_sum : '0);
      s2_low   <= lo_dn ? s1_val : low_seen;
      s2_high  <= hi_up ? s1_val : high_seen;
      s2_lowc  <= lo_dn;
      s2_highc <= hi_up;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: window average, threshold compare and calibration. Thresholds
  // are read and written only here, so an earlier calibrate of the same
  // channel has always landed before a sample compares against it.
  // ---------------------------------------------------------------------------
  logic [CH_W-1:0]   s2_idx;
  logic [VAL_W-1:0]  avg;
  logic [VAL_W+1:0]  avg_x3;
  logic [VAL_W-1:0]  cal_thr;
  logic [VAL_W-1:0]  thr_cur;
  logic [VAL_W-1:0]  thr_after;
  logic              s2_is_cal;
  logic              s2_is_sample;
  logic              s2_pressed;

  logic [VAL_W-1:0]  key_threshold [CHANNELS];

  tkwa_win_div #(
    .WINDOW (WINDOW),
    .VAL_W  (VAL_W)
  ) u_div (
    .sum  (s2_sum),
    .quot (avg)
  );

  assign s2_idx       = CH_W'(s2_ch);
  assign s2_is_cal    = s2_ok && (s2_op == OP_CALIBRATE);
  assign s2_is_sample = s2_ok && (s2_op == OP_SAMPLE);
  assign avg_x3       = {2'b00, avg} + {1'b0, avg, 1'b0};
  assign cal_thr      = avg_x3[VAL_W+1:2];
  assign thr_cur      = key_threshold[s2_idx];
  assign thr_after    = s2_is_cal ? cal_thr : thr_cur;
  assign s2_pressed   = s2_is_sample && (s2_val < thr_cur);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        key_threshold[c] <= VAL_W'(THRESH_RESET);
      end
    end else if (en && v2 && s2_is_cal) begin
      key_threshold[s2_idx] <= cal_thr;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register.
  // ---------------------------------------------------------------------------
  logic                out_valid;
  logic [CHAN_W-1:0]   o_ch;
  logic                o_pressed;
  logic [FIELD_W-1:0]  o_avg;
  logic [FIELD_W-1:0]  o_low;
  logic [FIELD_W-1:0]  o_high;
  logic                o_lowc;
  logic                o_highc;
  logic [FIELD_W-1:0]  o_thr;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en && v2) begin
      o_ch      <= s2_ch;
      o_pressed <= s2_pressed;
      o_avg     <= s2_ok ? FIELD_W'(avg) : '0;
      o_low     <= FIELD_W'(s2_low);
      o_high    <= FIELD_W'(s2_high);
      o_lowc    <= s2_lowc;
      o_highc   <= s2_highc;
      o_thr     <= s2_ok ? FIELD_W'(thr_after) : '0;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, o_thr, o_highc, o_lowc, o_high, o_low, o_avg, o_pressed, o_ch};

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_slot_range : assert property (@(posedge clk) disable iff (rst)
    accept && in_ok |-> int'(cur_slot) < WINDOW)
    else $error("ring slot out of range");

  a_wrap_sets_filled : assert property (@(posedge clk) disable iff (rst)
    accept && in_is_sample && (cur_slot == LAST_SLOT) |=> filled[$past(in_idx)])
    else $error("ring wrap did not mark the channel as filled");

  a_both_marks_meet : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && o_lowc && o_highc |-> o_low == o_high)
    else $error("a sample moving both marks must leave them equal");

  a_bad_channel_quiet : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !(int'(o_ch) < CHANNELS) |->
      !o_pressed && !o_lowc && !o_highc && (o_thr == '0) && (o_avg == '0))
    else $error("result for an unknown channel is not zeroed");

  a_stall_holds_pipe : assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(v1) && $stable(v2))
    else $error("pipeline moved while the result was stalled");

endmodule

### verif/tkwa_result_checker.sv
module tkwa_result_checker #(
  parameter int WINDOW   = 24,
  parameter int CHANNELS = 9
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [tkwa_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  input  logic                            s_axis_tuser,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [tkwa_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic                            pready,
  input  logic [tkwa_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [tkwa_pkg::APB_DATA_W-1:0] pwdata,
  output int                              bad_reports,
  output int                              open_reports,
  output int                              reports_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import tkwa_pkg::*;

  localparam int SUM_W = FIELD_W + $clog2(WINDOW);

  // Laid out exactly like the result word, highest bits first.
  typedef struct packed {
    logic               pad;
    logic [FIELD_W-1:0] threshold;
    logic               high_changed;
    logic               low_changed;
    logic [FIELD_W-1:0] high_mark;
    logic [FIELD_W-1:0] low_mark;
    logic [FIELD_W-1:0] average;
    logic               pressed;
    logic [CHAN_W-1:0]  channel;
  } key_report_t;

  logic [FIELD_W-1:0] ring [CHANNELS][WINDOW];
  logic [SUM_W-1:0]   ring_sum [CHANNELS];
  logic [FIELD_W-1:0] key_thresh [CHANNELS];
  int unsigned        ring_pos [CHANNELS];
  logic [FIELD_W-1:0] low_seen;
  logic [FIELD_W-1:0] high_seen;
  logic [MASK_W-1:0]  button_mask;
  key_report_t        key_reports [$];
  int                 fails = 0;
  int                 seen = 0;

  // Updates the channel state for one accepted word and returns its report.
  function automatic key_report_t qualify_word(op_t op, logic [CHAN_W-1:0] ch,
                                               logic [FIELD_W-1:0] raw);
    key_report_t        r;
    logic [FIELD_W-1:0] val;
    logic [FIELD_W-1:0] old_val;
    r = '0;
    r.channel = ch;
    if (ch < CHANNELS) begin
      if (op == OP_CALIBRATE) begin
        key_thresh[ch] = FIELD_W'((ring_sum[ch] / WINDOW) * 3 / 4);
      end else begin
        if (ch < MASK_W && button_mask[ch]) begin
          val = raw[0] ? FIELD_W'(DIGITAL_HELD) : FIELD_W'(DIGITAL_IDLE);
        end else begin
          val = raw;
        end
        old_val = ring[ch][ring_pos[ch]];
        ring[ch][ring_pos[ch]] = val;
        ring_sum[ch] = ring_sum[ch] - old_val + val;
        ring_pos[ch] = (ring_pos[ch] + 1 == WINDOW) ? 0 : ring_pos[ch] + 1;
        r.pressed = val < key_thresh[ch];
        if (val > high_seen) begin
          high_seen = val;
          r.high_changed = 1'b1;
        end
        if (val < low_seen) begin
          low_seen = val;
          r.low_changed = 1'b1;
        end
      end
      r.average   = FIELD_W'(ring_sum[ch] / WINDOW);
      r.threshold = key_thresh[ch];
    end
    r.low_mark  = low_seen;
    r.high_mark = high_seen;
    return r;
  endfunction

  function automatic logic [FIELD_W-1:0] report_field(key_report_t r, int i);
    case (i)
      0:       return FIELD_W'(r.channel);
      1:       return FIELD_W'(r.pressed);
      2:       return r.average;
      3:       return r.low_mark;
      4:       return r.high_mark;
      5:       return FIELD_W'(r.low_changed);
      6:       return FIELD_W'(r.high_changed);
      default: return r.threshold;
    endcase
  endfunction

  function automatic string field_label(int i);
    case (i)
      0:       return "channel_out";
      1:       return "pressed";
      2:       return "window_average";
      3:       return "low_mark";
      4:       return "high_mark";
      5:       return "low_changed";
      6:       return "high_changed";
      default: return "threshold_now";
    endcase
  endfunction

  always @(posedge clk) begin : track
    key_report_t want;
    key_report_t got;
    bit          wrong;
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        for (int s = 0; s < WINDOW; s++) ring[c][s] = '0;
        ring_sum[c]   = '0;
        key_thresh[c] = FIELD_W'(THRESH_RESET);
        ring_pos[c]   = 0;
      end
      low_seen    = FIELD_W'(LOW_RESET);
      high_seen   = '0;
      button_mask = MASK_RESET;
      key_reports.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == ADDR_DIGITAL_MASK) begin
        button_mask = pwdata[MASK_W-1:0];
      end
      if (s_axis_tvalid && s_axis_tready) begin
        key_reports.push_back(qualify_word(op_t'(s_axis_tuser), s_axis_tdata[CHAN_W-1:0],
                                           s_axis_tdata[CHAN_W +: FIELD_W]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        seen++;
        if (key_reports.size() == 0) begin
          $error("result word %0d arrived with nothing pending", seen);
          fails++;
        end else begin
          want  = key_reports.pop_front();
          got   = key_report_t'(m_axis_tdata);
          wrong = 1'b0;
          for (int i = 0; i < 8; i++) begin
            if (report_field(want, i) !== report_field(got, i)) begin
              $error("result word %0d, %s: expected %0d, actual %0d", seen,
                     field_label(i), report_field(want, i), report_field(got, i));
              wrong = 1'b1;
            end
          end
          if (wrong) fails++;
        end
      end
    end
    bad_reports  <= fails;
    open_reports <= key_reports.size();
    reports_seen <= seen;
  end

endmodule

### verif/tb_touch_key_window_average_core.sv
module tb_touch_key_window_average_core;
  timeunit 1ns;
  timeprecision 1ps;
  import tkwa_pkg::*;

  localparam int CHANNELS = 9;
  localparam int WINDOW   = 24;

  // Number of counted words in each random phase; four phases in all.
  localparam int PHASE_WORDS = 375;

  typedef enum int {
    DRAIN_ALWAYS,
    DRAIN_RANDOM,
    DRAIN_CHOPPY,
    DRAIN_SPARSE
  } drain_mode_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // [3:0] channel, [19:4] sample, [23:20] zero.
  logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
  // [0] op.
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // [3:0] channel_out, [4] pressed, [20:5] window_average, [36:21] low_mark,
  // [52:37] high_mark, [53] low_changed, [54] high_changed,
  // [70:55] threshold_now, [71] zero.
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int bad_reports;
  int open_reports;
  int reports_seen;

  // Tallies for the closing summary.
  int words_sent    = 0;
  int calibrations  = 0;
  int foreign_words = 0;
  int mask_settings = 1;

  always #10ns clk = ~clk;

  touch_key_window_average_core #(
    .WINDOW      (WINDOW),
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (FIELD_W)
  ) uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // The checker sees the same pins as the block and keeps its own copy of the
  // channel rings, thresholds and marks.
  tkwa_result_checker #(
    .WINDOW   (WINDOW),
    .CHANNELS (CHANNELS)
  ) report_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .bad_reports   (bad_reports),
    .open_reports  (open_reports),
    .reports_seen  (reports_seen)
  );

  // Result-side back-pressure. The drain switches between modes at random:
  // always ready, randomly ready, a short periodic stall and a sparse pattern
  // that holds results inside the pipeline for a long time.
  drain_mode_t drain_mode = DRAIN_ALWAYS;
  int unsigned drain_left = 0;
  int unsigned drain_tick = 0;

  always @(posedge clk) begin
    if (drain_left == 0) begin
      drain_mode = drain_mode_t'($urandom_range(0, 3));
      drain_left = $urandom_range(40, 300);
    end else begin
      drain_left--;
    end
    drain_tick++;
    case (drain_mode)
      DRAIN_ALWAYS: m_axis_tready <= 1'b1;
      DRAIN_RANDOM: m_axis_tready <= ($urandom_range(0, 9) < 7);
      DRAIN_CHOPPY: m_axis_tready <= (drain_tick % 5) < 2;
      default:      m_axis_tready <= (drain_tick % 9) == 0;
    endcase
  end

  // Presents one word and returns at the edge that accepts it. The caller is
  // always at a rising edge, so tvalid is never lowered and raised in one step.
  task automatic push_word(op_t op, logic [CHAN_W-1:0] ch, logic [FIELD_W-1:0] value);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{(S_TDATA_W - CHAN_W - FIELD_W){1'b0}}, value, ch};
    do @(posedge clk); while (!s_axis_tready);
    words_sent++;
    if (op == OP_CALIBRATE) calibrations++;
    if (ch >= CHANNELS) foreign_words++;
  endtask

  task automatic hold_off(int cycles);
    s_axis_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // The mask is only changed with the pipeline empty: every word produces a
  // result, so an empty expectation queue followed by a wait means idle.
  task automatic write_mask(logic [MASK_W-1:0] value);
    while (open_reports != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_DIGITAL_MASK;
    pwdata  <= APB_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    mask_settings++;
  endtask

  // Random traffic in bursts. Each burst favors one channel so that the same
  // ring is hit on back-to-back words and wraps many times, and sample values
  // cluster around a burst level so averages, calibration and the pressed
  // flag all see meaningful numbers. A few words go to channels past the last
  // one; those change no channel state and do not count toward the phase.
  task automatic run_phase(int count);
    int                 left;
    int                 burst;
    int                 gap;
    int                 pick;
    logic [CHAN_W-1:0]  hot;
    logic [CHAN_W-1:0]  ch;
    logic [FIELD_W-1:0] level;
    logic [FIELD_W-1:0] value;
    op_t                op;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 40);
      hot   = CHAN_W'($urandom_range(0, CHANNELS - 1));
      level = ($urandom_range(0, 3) == 0) ? FIELD_W'($urandom)
                                          : FIELD_W'($urandom_range(20, 160));
      for (int k = 0; k < burst && left > 0; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 5) ch = CHAN_W'($urandom_range(CHANNELS, 15));
        else if (pick < 65) ch = hot;
        else ch = CHAN_W'($urandom_range(0, CHANNELS - 1));
        op = ($urandom_range(0, 99) < 8) ? OP_CALIBRATE : OP_SAMPLE;
        case ($urandom_range(0, 9))
          0, 1:    value = FIELD_W'($urandom);
          2:       value = $urandom_range(0, 1) ? 16'hFFFF - FIELD_W'($urandom_range(0, 1))
                                                : FIELD_W'($urandom_range(0, 1));
          3, 4, 5: value = FIELD_W'($urandom_range(0, 200));
          default: value = level + FIELD_W'($urandom_range(0, 16)) - FIELD_W'(8);
        endcase
        push_word(op, ch, value);
        if (ch < CHANNELS) left--;
      end
      case ($urandom_range(0, 7))
        0, 1, 2: gap = 0;
        7:       gap = $urandom_range(10, 30);
        default: gap = $urandom_range(1, 4);
      endcase
      if (gap > 0) hold_off(gap);
    end
    hold_off(1);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words under the reset mask, where channels 7 and 8 are buttons.
    push_word(OP_SAMPLE, 4'd0, 16'd40);        // below threshold, raises the high mark
    push_word(OP_SAMPLE, 4'd0, 16'd0);         // smallest value pulls the low mark down
    push_word(OP_SAMPLE, 4'd1, 16'hFFFF);      // largest value
    push_word(OP_SAMPLE, 4'd2, 16'd70);        // equal to threshold: not pressed
    push_word(OP_SAMPLE, 4'd2, 16'd69);        // one below threshold: pressed
    push_word(OP_SAMPLE, 4'd7, 16'h0001);      // button held
    push_word(OP_SAMPLE, 4'd7, 16'hFFFE);      // button released, upper bits ignored
    push_word(OP_SAMPLE, 4'd8, 16'hFFFF);      // held on the top channel
    push_word(OP_CALIBRATE, 4'd0, 16'd0);      // tiny average gives a zero threshold
    push_word(OP_CALIBRATE, 4'd5, 16'hFFFF);   // calibrate a channel never sampled
    push_word(OP_SAMPLE, 4'd5, 16'd0);         // zero is not below a zero threshold
    push_word(OP_CALIBRATE, 4'd1, 16'd0);      // threshold from a large average
    push_word(OP_SAMPLE, 4'd1, 16'd2000);      // below the new threshold
    push_word(OP_SAMPLE, 4'd9, 16'h1234);      // first channel past the last one
    push_word(OP_CALIBRATE, 4'd15, 16'hFFFF);  // highest channel code, calibrate
    push_word(OP_SAMPLE, 4'd12, 16'h8001);     // ignored sample
    push_word(OP_SAMPLE, 4'd3, 16'hAAAA);
    push_word(OP_SAMPLE, 4'd4, 16'h5555);
    push_word(OP_SAMPLE, 4'd6, 16'h8000);
    push_word(OP_CALIBRATE, 4'd7, 16'd0);      // calibrate a button channel
    push_word(OP_SAMPLE, 4'd7, 16'd0);
    hold_off(1);

    // Random phases, each under a different button mask: reset value,
    // all analog, all buttons, then an arbitrary mix.
    run_phase(PHASE_WORDS);
    write_mask('0);
    run_phase(PHASE_WORDS);
    write_mask('1);
    run_phase(PHASE_WORDS);
    write_mask(MASK_W'($urandom_range(1, 510)));
    run_phase(PHASE_WORDS);

    // Drain, then give any stray result time to show up.
    while (open_reports != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("Sent %0d words (%0d calibrate, %0d to channels past the last one)",
             words_sent, calibrations, foreign_words);
    $display("under %0d button mask settings; %0d result words compared.",
             mask_settings, reports_seen);
    if (bad_reports == 0) begin
      $display("touch_key_window_average_core: match");
    end else begin
      $display("touch_key_window_average_core: mismatch");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #4ms;
    $display("Run timed out with %0d results still outstanding.", open_reports);
    $display("touch_key_window_average_core: mismatch");
    $finish;
  end

endmodule
